@@ rtl/tweb_pkg.sv @@
// Shared types and constants for the time-window event builder.
// Used by tweb_cfg, tweb_ctrl, tweb_dp and time_window_event_builder.
package tweb_pkg;

  localparam int NUM_BOARDS_DEF = 4;
  localparam int CHANNELS       = 16;
  localparam int CH_W           = 4;
  localparam int TS_W           = 48;
  localparam int NS_W           = 52;
  localparam int CFG_AW         = 5;

  localparam logic [31:0] WINDOW_RST = 32'd1000;
  localparam logic [2:0]  REG_WINDOW = 3'd0;

  localparam logic [9:0] RATE_100 = 10'd100;
  localparam logic [9:0] RATE_250 = 10'd250;
  localparam logic [9:0] RATE_500 = 10'd500;

  localparam logic [6:0] FIRST_SLOT = 7'd2;

  typedef struct packed {
    logic [9:0]         rate;
    logic [15:0]        energy;
    logic [TS_W-1:0]    ts;
    logic [1:0]         flags;
    logic signed [15:0] cfd_fraction;
    logic signed [15:0] cfd_source;
  } slot_entry_t;

  typedef struct packed {
    logic load_in;
    logic scale;
    logic track;
    logic open;
    logic store;
    logic sweep;
    logic emit_load;
    logic close;
  } dp_cmd_t;

  typedef struct packed {
    logic flush;
    logic in_window;
    logic out_free;
    logic last_slot;
  } dp_status_t;

  typedef logic [7:0][5:0] first_board_t;

endpackage

@@ rtl/tweb_cfg.sv @@
// Configuration registers behind an APB-style port: window and crate offsets.
// Depends on tweb_pkg.
module tweb_cfg import tweb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [31:0]       window_ns,
  output first_board_t      first_board
);

  logic [31:0]  window_r;
  first_board_t first_r;
  logic [2:0]   reg_idx;
  logic         wr_en;

  assign reg_idx = paddr[CFG_AW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RST;
      first_r  <= '0;
    end else if (wr_en) begin
      if (reg_idx == REG_WINDOW) begin
        window_r <= pwdata;
      end else begin
        first_r[reg_idx] <= pwdata[5:0];
      end
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WINDOW: prdata = window_r;
      default:    prdata = {26'b0, first_r[reg_idx]};
    endcase
  end

  assign window_ns   = window_r;
  assign first_board = first_r;

endmodule

@@ rtl/tweb_ctrl.sv @@
// Controller state machine for the event builder.
// Depends on tweb_pkg; drives tweb_dp through dp_cmd_t.
module tweb_ctrl import tweb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  dp_status_t status,
  output logic       in_stall,
  output dp_cmd_t    cmd
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_SCALE   = 9'b000000010,
    S_EVAL    = 9'b000000100,
    S_CMP     = 9'b000001000,
    S_OPEN    = 9'b000010000,
    S_STORE   = 9'b000100000,
    S_EMIT_RD = 9'b001000000,
    S_EMIT_LD = 9'b010000000,
    S_CLOSE   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   open_r, open_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      open_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      open_r  <= open_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    open_nxt  = open_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (status.flush) begin
          state_nxt = open_r ? S_EMIT_RD : S_IDLE;
        end else if (!open_r) begin
          state_nxt = S_OPEN;
        end else begin
          cmd.track = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = status.in_window ? S_STORE : S_EMIT_RD;
      end
      S_OPEN: begin
        cmd.open  = 1'b1;
        open_nxt  = 1'b1;
        state_nxt = S_STORE;
      end
      S_STORE: begin
        cmd.store = 1'b1;
        state_nxt = S_IDLE;
      end
      S_EMIT_RD: begin
        cmd.sweep = 1'b1;
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd.sweep = 1'b1;
        if (status.out_free) begin
          cmd.emit_load = 1'b1;
          state_nxt     = status.last_slot ? S_CLOSE : S_EMIT_RD;
        end
      end
      S_CLOSE: begin
        cmd.close = 1'b1;
        if (status.flush) begin
          open_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_OPEN;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

@@ rtl/tweb_dp.sv @@
// Datapath: input registers, time scaling, window check, slot table memory
// with valid bits, sweep counter and output register. Depends on tweb_pkg.
module tweb_dp import tweb_pkg::*; #(
  parameter int NUM_BOARDS = NUM_BOARDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  input  logic [31:0]        window_ns,
  input  first_board_t       first_board,
  input  logic               in_mode,
  input  logic [9:0]         in_rate_mhz,
  input  logic [2:0]         in_crate,
  input  logic [4:0]         in_slot,
  input  logic [3:0]         in_channel,
  input  logic [15:0]        in_energy,
  input  logic [TS_W-1:0]    in_timestamp,
  input  logic [1:0]         in_hit_flags,
  input  logic signed [15:0] in_cfd_fraction,
  input  logic signed [15:0] in_cfd_source,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [31:0]        out_event_number,
  output logic [5:0]         out_slot_index,
  output logic [9:0]         out_rate_mhz_out,
  output logic [15:0]        out_energy_out,
  output logic [TS_W-1:0]    out_timestamp_out,
  output logic [1:0]         out_hit_flags_out,
  output logic signed [15:0] out_cfd_fraction_out,
  output logic signed [15:0] out_cfd_source_out,
  output logic               out_last
);

  localparam int TABLE = NUM_BOARDS * CHANNELS;
  localparam int IDXW  = $clog2(TABLE);

  logic            mode_r;
  slot_entry_t     hit_r;
  logic [2:0]      crate_r;
  logic [4:0]      slot_r;
  logic [CH_W-1:0] ch_r;

  logic [NS_W-1:0] ns_r, sht_r, start_r, dist_r;
  logic            known_r, idx_ok_r;
  logic [IDXW-1:0] idx_r, cnt_r, rd_addr;
  logic [31:0]     event_count_r;
  logic [TABLE-1:0] valid_r;

  slot_entry_t     mem [TABLE];
  slot_entry_t     rd_r, emit_entry;

  logic            out_valid_r;

  // Board index and scaled time.
  logic [6:0]         board_sum, board;
  logic [6+CH_W:0]    idx_full;
  logic               idx_ok;
  logic [NS_W-1:0]    ts_ext, ns_x10, ns_x8, ns;
  logic               known;
  logic [NS_W-1:0]    a_time, d2;
  logic [NS_W:0]      d1;
  logic [NS_W-1:0]    gap;
  logic [15:0]        stored_energy;
  logic               wr_en;
  logic               last_slot;

  assign board_sum = {1'b0, first_board[crate_r]} + {2'b0, slot_r};
  assign board     = board_sum - FIRST_SLOT;
  assign idx_ok    = (board_sum >= FIRST_SLOT) && (board < 7'(NUM_BOARDS));
  assign idx_full  = {board, ch_r};

  assign ts_ext = {{(NS_W-TS_W){1'b0}}, hit_r.ts};
  assign ns_x10 = (ts_ext << 3) + (ts_ext << 1);
  assign ns_x8  = ts_ext << 3;

  always_comb begin
    known = 1'b1;
    ns    = ns_x10;
    unique case (hit_r.rate) inside
      RATE_100, RATE_500: ns = ns_x10;
      RATE_250:           ns = ns_x8;
      default:            known = 1'b0;
    endcase
  end

  assign a_time = known_r ? ns_r : sht_r;
  assign d1     = {1'b0, a_time} - {1'b0, start_r};
  assign d2     = start_r - a_time;
  assign gap    = d1[NS_W] ? d2 : d1[NS_W-1:0];

  assign stored_energy = valid_r[idx_r] ? rd_r.energy : 16'd0;
  assign wr_en         = cmd.store && idx_ok_r && (hit_r.energy >= stored_energy);
  assign rd_addr       = cmd.sweep ? cnt_r : idx_r;
  assign last_slot     = (cnt_r == IDXW'(TABLE - 1));
  assign emit_entry    = valid_r[cnt_r] ? rd_r : '0;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r             <= in_mode;
      hit_r.rate         <= in_rate_mhz;
      hit_r.energy       <= in_energy;
      hit_r.ts           <= in_timestamp;
      hit_r.flags        <= in_hit_flags;
      hit_r.cfd_fraction <= in_cfd_fraction;
      hit_r.cfd_source   <= in_cfd_source;
      crate_r            <= in_crate;
      slot_r             <= in_slot;
      ch_r               <= in_channel;
    end
    if (cmd.scale) begin
      ns_r     <= ns;
      known_r  <= known;
      idx_r    <= idx_full[IDXW-1:0];
      idx_ok_r <= idx_ok;
    end
    if (cmd.track) begin
      dist_r <= gap;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx_r] <= hit_r;
    end
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r       <= '0;
      sht_r         <= '0;
      event_count_r <= '0;
      valid_r       <= '0;
      cnt_r         <= '0;
    end else begin
      if (cmd.track) begin
        sht_r <= a_time;
      end
      if (cmd.open && known_r) begin
        start_r <= ns_r;
      end
      if (cmd.close) begin
        event_count_r <= event_count_r + 32'd1;
      end
      if (cmd.open || cmd.close) begin
        valid_r <= '0;
      end else if (wr_en) begin
        valid_r[idx_r] <= 1'b1;
      end
      if (cmd.emit_load) begin
        cnt_r <= last_slot ? '0 : cnt_r + IDXW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_event_number     <= event_count_r;
      out_slot_index       <= 6'(cnt_r);
      out_rate_mhz_out     <= emit_entry.rate;
      out_energy_out       <= emit_entry.energy;
      out_timestamp_out    <= emit_entry.ts;
      out_hit_flags_out    <= emit_entry.flags;
      out_cfd_fraction_out <= emit_entry.cfd_fraction;
      out_cfd_source_out   <= emit_entry.cfd_source;
      out_last             <= last_slot;
    end
  end

  assign out_valid = out_valid_r;

  assign status.flush     = mode_r;
  assign status.in_window = (dist_r <= {{(NS_W-32){1'b0}}, window_ns});
  assign status.out_free  = !out_valid_r || !out_stall;
  assign status.last_slot = last_slot;

endmodule

@@ rtl/time_window_event_builder.sv @@
// Time-window event builder top level: tweb_cfg, tweb_ctrl, tweb_dp; uses tweb_pkg.
// A hit that stays in the event passes load, scale, evaluate, compare or open and table write
// before the next acceptance; a flush with no open event passes load, scale and evaluate only.
// A closing hit sweeps NUM_BOARDS*16 items, each a slot read then an output load, then closes
// the event and opens a new one with that hit; a flush closes the event without reopening.
// Output stall holds the sweep. Synchronous active-low reset clears control, counters, valid bits.
module time_window_event_builder import tweb_pkg::*; #(
  parameter int NUM_BOARDS = NUM_BOARDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic [9:0]         in_rate_mhz,
  input  logic [2:0]         in_crate,
  input  logic [4:0]         in_slot,
  input  logic [3:0]         in_channel,
  input  logic [15:0]        in_energy,
  input  logic [TS_W-1:0]    in_timestamp,
  input  logic [1:0]         in_hit_flags,
  input  logic signed [15:0] in_cfd_fraction,
  input  logic signed [15:0] in_cfd_source,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_event_number,
  output logic [5:0]         out_slot_index,
  output logic [9:0]         out_rate_mhz_out,
  output logic [15:0]        out_energy_out,
  output logic [TS_W-1:0]    out_timestamp_out,
  output logic [1:0]         out_hit_flags_out,
  output logic signed [15:0] out_cfd_fraction_out,
  output logic signed [15:0] out_cfd_source_out,
  output logic               out_last
);

  localparam int TABLE = NUM_BOARDS * CHANNELS;

  logic [31:0]  window_ns;
  first_board_t first_board;
  dp_cmd_t      cmd;
  dp_status_t   status;

  tweb_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .window_ns   (window_ns),
    .first_board (first_board)
  );

  tweb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  tweb_dp #(
    .NUM_BOARDS (NUM_BOARDS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .window_ns            (window_ns),
    .first_board          (first_board),
    .in_mode              (in_mode),
    .in_rate_mhz          (in_rate_mhz),
    .in_crate             (in_crate),
    .in_slot              (in_slot),
    .in_channel           (in_channel),
    .in_energy            (in_energy),
    .in_timestamp         (in_timestamp),
    .in_hit_flags         (in_hit_flags),
    .in_cfd_fraction      (in_cfd_fraction),
    .in_cfd_source        (in_cfd_source),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_event_number     (out_event_number),
    .out_slot_index       (out_slot_index),
    .out_rate_mhz_out     (out_rate_mhz_out),
    .out_energy_out       (out_energy_out),
    .out_timestamp_out    (out_timestamp_out),
    .out_hit_flags_out    (out_hit_flags_out),
    .out_cfd_fraction_out (out_cfd_fraction_out),
    .out_cfd_source_out   (out_cfd_source_out),
    .out_last             (out_last)
  );

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_load |-> status.out_free)
    else $error("output register overwritten while an item waits");

  a_load_then_scale: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_in |=> cmd.scale)
    else $error("accepted item not scaled in the next cycle");

  a_last_then_close: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_load && status.last_slot) |=> (cmd.close && !cmd.emit_load))
    else $error("event not closed after its final slot");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_slot_index == 6'(TABLE - 1)))
    else $error("last flag on a slot other than the final one");

endmodule

@@ verif/tweb_readout_checker.sv @@
// Checker for time_window_event_builder: tracks register writes, predicts event readouts
// from accepted items and compares every accepted result item field by field.
// Depends on tweb_pkg.
`timescale 1ns / 1ps
module tweb_readout_checker import tweb_pkg::*; #(
  parameter int NUM_BOARDS = NUM_BOARDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [31:0]        pwdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_mode,
  input  logic [9:0]         in_rate_mhz,
  input  logic [2:0]         in_crate,
  input  logic [4:0]         in_slot,
  input  logic [3:0]         in_channel,
  input  logic [15:0]        in_energy,
  input  logic [TS_W-1:0]    in_timestamp,
  input  logic [1:0]         in_hit_flags,
  input  logic signed [15:0] in_cfd_fraction,
  input  logic signed [15:0] in_cfd_source,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [31:0]        out_event_number,
  input  logic [5:0]         out_slot_index,
  input  logic [9:0]         out_rate_mhz_out,
  input  logic [15:0]        out_energy_out,
  input  logic [TS_W-1:0]    out_timestamp_out,
  input  logic [1:0]         out_hit_flags_out,
  input  logic signed [15:0] out_cfd_fraction_out,
  input  logic signed [15:0] out_cfd_source_out,
  input  logic               out_last,
  output int unsigned        readouts_pending,
  output int unsigned        mismatch_count
);

  localparam int TABLE_SIZE = NUM_BOARDS * CHANNELS;

  typedef struct packed {
    logic [31:0] event_no;
    logic [5:0]  index;
    slot_entry_t entry;
    logic        last;
  } readout_t;

  readout_t     expected_readout[$];
  slot_entry_t  hit_table[TABLE_SIZE];
  logic [31:0]  window;
  first_board_t first_board;
  logic         building;
  logic [NS_W-1:0] start_ns;
  logic [NS_W-1:0] hit_ns;
  logic [31:0]  event_cnt;
  int unsigned  n_err = 0;

  function automatic logic scale_ns(input logic [9:0] rate, input logic [TS_W-1:0] ts,
                                    output logic [NS_W-1:0] ns);
    ns = '0;
    if (rate == RATE_100 || rate == RATE_500) begin
      ns = NS_W'(ts) * NS_W'(10);
      return 1'b1;
    end
    if (rate == RATE_250) begin
      ns = NS_W'(ts) * NS_W'(8);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report(input string msg);
    n_err++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want, input readout_t e);
    if (got !== want)
      report($sformatf("event %0d slot %0d %s: got 0x%0h, expected 0x%0h",
                       e.event_no, e.index, name, got, want));
  endtask

  task automatic clear_table();
    for (int k = 0; k < TABLE_SIZE; k++) hit_table[k] = '0;
  endtask

  task automatic store_hit();
    int board;
    int idx;
    board = int'(first_board[in_crate]) + int'(in_slot) - int'(FIRST_SLOT);
    if (board < 0 || board >= NUM_BOARDS) return;
    idx = board * CHANNELS + int'(in_channel);
    if (in_energy >= hit_table[idx].energy) begin
      hit_table[idx].rate         = in_rate_mhz;
      hit_table[idx].energy       = in_energy;
      hit_table[idx].ts           = in_timestamp;
      hit_table[idx].flags        = in_hit_flags;
      hit_table[idx].cfd_fraction = in_cfd_fraction;
      hit_table[idx].cfd_source   = in_cfd_source;
    end
  endtask

  task automatic emit_readout();
    readout_t r;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      r.event_no = event_cnt;
      r.index    = 6'(k);
      r.entry    = hit_table[k];
      r.last     = (k == TABLE_SIZE - 1);
      expected_readout.push_back(r);
    end
    event_cnt++;
    clear_table();
  endtask

  task automatic open_event(input logic known, input logic [NS_W-1:0] ns);
    clear_table();
    if (known) start_ns = ns;
    building = 1'b1;
    store_hit();
  endtask

  task automatic apply_item();
    logic            known;
    logic [NS_W-1:0] ns;
    logic [NS_W-1:0] gap;
    known = scale_ns(in_rate_mhz, in_timestamp, ns);
    if (in_mode) begin
      if (building) begin
        emit_readout();
        building = 1'b0;
      end
    end else if (!building) begin
      open_event(known, ns);
    end else begin
      if (known) hit_ns = ns;
      gap = (hit_ns >= start_ns) ? hit_ns - start_ns : start_ns - hit_ns;
      if (gap <= NS_W'(window)) begin
        store_hit();
      end else begin
        emit_readout();
        open_event(known, ns);
      end
    end
  endtask

  task automatic check_readout();
    readout_t e;
    if (expected_readout.size() == 0) begin
      report($sformatf("result item for event %0d slot %0d with nothing expected",
                       out_event_number, out_slot_index));
      return;
    end
    e = expected_readout.pop_front();
    check_field("event_number", out_event_number, e.event_no, e);
    check_field("slot_index", out_slot_index, e.index, e);
    check_field("rate_mhz", out_rate_mhz_out, e.entry.rate, e);
    check_field("energy", out_energy_out, e.entry.energy, e);
    check_field("timestamp", out_timestamp_out, e.entry.ts, e);
    check_field("hit_flags", out_hit_flags_out, e.entry.flags, e);
    check_field("cfd_fraction", out_cfd_fraction_out, e.entry.cfd_fraction, e);
    check_field("cfd_source", out_cfd_source_out, e.entry.cfd_source, e);
    check_field("last", out_last, e.last, e);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      window      = WINDOW_RST;
      first_board = '0;
      building    = 1'b0;
      start_ns    = '0;
      hit_ns      = '0;
      event_cnt   = '0;
      clear_table();
      expected_readout.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[CFG_AW-1:2] == REG_WINDOW) window = pwdata;
        else first_board[paddr[CFG_AW-1:2]] = pwdata[5:0];
      end
      if (out_valid && !out_stall) check_readout();
      if (in_valid && !in_stall) apply_item();
    end
    readouts_pending <= expected_readout.size();
    mismatch_count   <= n_err;
  end

endmodule

@@ verif/tb_time_window_event_builder.sv @@
// Testbench top for time_window_event_builder: clock, reset, register phases, directed and
// random hit streams with bursty input and stalling output, final verdict.
// Depends on tweb_pkg, time_window_event_builder and tweb_readout_checker.
`timescale 1ns / 1ps
module tb_time_window_event_builder import tweb_pkg::*;;

  typedef struct packed {
    logic               mode;
    logic [9:0]         rate;
    logic [2:0]         crate;
    logic [4:0]         slot;
    logic [3:0]         channel;
    logic [15:0]        energy;
    logic [TS_W-1:0]    ts;
    logic [1:0]         flags;
    logic signed [15:0] cfd_fraction;
    logic signed [15:0] cfd_source;
  } hit_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [CFG_AW-1:0]  paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_mode = 1'b0;
  logic [9:0]         in_rate_mhz = '0;
  logic [2:0]         in_crate = '0;
  logic [4:0]         in_slot = '0;
  logic [3:0]         in_channel = '0;
  logic [15:0]        in_energy = '0;
  logic [TS_W-1:0]    in_timestamp = '0;
  logic [1:0]         in_hit_flags = '0;
  logic signed [15:0] in_cfd_fraction = '0;
  logic signed [15:0] in_cfd_source = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [31:0]        out_event_number;
  logic [5:0]         out_slot_index;
  logic [9:0]         out_rate_mhz_out;
  logic [15:0]        out_energy_out;
  logic [TS_W-1:0]    out_timestamp_out;
  logic [1:0]         out_hit_flags_out;
  logic signed [15:0] out_cfd_fraction_out;
  logic signed [15:0] out_cfd_source_out;
  logic               out_last;
  int unsigned        readouts_pending;
  int unsigned        mismatch_count;

  logic        hold_req = 1'b0;
  int          burst_left = 0;
  logic [31:0] window_val = WINDOW_RST;
  logic [5:0]  first_val[8] = '{default: 6'd0};
  logic [15:0] last_energy = '0;

  time_window_event_builder u_dut (.*);

  tweb_readout_checker u_checker (.*);

  initial forever #4 clk = ~clk;

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_window(input logic [31:0] val);
    window_val = val;
    reg_write(REG_WINDOW, val);
  endtask

  task automatic set_first_board(input int crate, input logic [5:0] val);
    first_val[crate] = val;
    reg_write(3'(crate), 32'(val));
  endtask

  task automatic send_item(input hit_t h);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_mode         <= h.mode;
    in_rate_mhz     <= h.rate;
    in_crate        <= h.crate;
    in_slot         <= h.slot;
    in_channel      <= h.channel;
    in_energy       <= h.energy;
    in_timestamp    <= h.ts;
    in_hit_flags    <= h.flags;
    in_cfd_fraction <= h.cfd_fraction;
    in_cfd_source   <= h.cfd_source;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (readouts_pending == 0);
    repeat (12) @(posedge clk);
  endtask

  function automatic hit_t mk_hit(input logic [9:0] rate, input logic [2:0] crate,
                                  input logic [4:0] slot, input logic [3:0] channel,
                                  input logic [15:0] energy, input logic [TS_W-1:0] ts,
                                  input logic [1:0] flags, input logic signed [15:0] frac,
                                  input logic signed [15:0] src);
    hit_t h;
    h.mode         = 1'b0;
    h.rate         = rate;
    h.crate        = crate;
    h.slot         = slot;
    h.channel      = channel;
    h.energy       = energy;
    h.ts           = ts;
    h.flags        = flags;
    h.cfd_fraction = frac;
    h.cfd_source   = src;
    return h;
  endfunction

  function automatic hit_t flush_item();
    hit_t h;
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    h = r[$bits(hit_t)-1:0];
    h.mode = 1'b1;
    return h;
  endfunction

  function automatic logic [NS_W-1:0] rand_base();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return NS_W'((r[50:0] / 40) * 40);
  endfunction

  function automatic logic [TS_W-1:0] ns_to_ts(input logic [9:0] rate,
                                               input logic [NS_W-1:0] ns);
    if (rate == RATE_100 || rate == RATE_500) return TS_W'(ns / 10);
    if (rate == RATE_250) return TS_W'(ns / 8);
    return TS_W'({$urandom, $urandom});
  endfunction

  function automatic hit_t random_hit(input logic [NS_W-1:0] base);
    hit_t            h;
    int              pick;
    int              board;
    int              s;
    int unsigned     lim;
    int unsigned     d;
    logic [NS_W-1:0] t;
    h = flush_item();
    h.mode = 1'b0;
    pick = $urandom_range(0, 19);
    if (pick == 0) h.rate = 10'($urandom);
    else if (pick < 7) h.rate = RATE_100;
    else if (pick < 13) h.rate = RATE_250;
    else h.rate = RATE_500;
    lim = (window_val > 100000) ? 100000 : window_val;
    d = ($urandom_range(0, lim) / 40) * 40;
    t = ($urandom_range(0, 1) == 1 && base >= NS_W'(d)) ? base - NS_W'(d) : base + NS_W'(d);
    if (pick == 1) t = rand_base();
    h.ts = ns_to_ts(h.rate, t);
    board = $urandom_range(0, NUM_BOARDS_DEF - 1);
    s = board + int'(FIRST_SLOT) - int'(first_val[h.crate]);
    if (s < 0 || s > 31) begin
      h.crate = '0;
      s = board + int'(FIRST_SLOT);
    end
    h.slot = 5'(s);
    if ($urandom_range(0, 9) == 0) begin
      h.crate = 3'($urandom);
      h.slot  = 5'($urandom);
    end
    h.channel = ($urandom_range(0, 1) == 1) ? 4'($urandom_range(0, 3)) : 4'($urandom);
    if ($urandom_range(0, 4) == 0) h.energy = last_energy;
    last_energy = h.energy;
    return h;
  endfunction

  task automatic random_events(input int n_items);
    logic [NS_W-1:0] base;
    int              sent;
    int              k;
    sent = 0;
    while (sent < n_items) begin
      base = rand_base();
      k = $urandom_range(1, 8);
      for (int i = 0; i < k && sent < n_items; i++) begin
        send_item(random_hit(base));
        sent++;
      end
      if ($urandom_range(0, 4) == 0) begin
        send_item(flush_item());
        sent++;
      end
    end
    send_item(flush_item());
  endtask

  // receiver: changing stall patterns, one long hold-off when requested
  initial begin
    int pat;
    int pat_left;
    pat = 0;
    pat_left = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req && out_valid) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end
      if (pat_left == 0) begin
        pat = $urandom_range(0, 3);
        pat_left = $urandom_range(10, 80);
      end
      pat_left--;
      case (pat)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: window 1000 ns, all crates start at board 0
    send_item(flush_item());
    send_item(mk_hit(RATE_100, 3'd0, 5'd2, 4'd0, 16'h8000, 48'd1000, 2'd0, 16'sd0, 16'sd0));
    send_item(mk_hit(RATE_100, 3'd0, 5'd2, 4'd0, 16'h7FFF, 48'd1001, 2'd1, 16'sd5, -16'sd5));
    send_item(mk_hit(RATE_250, 3'd0, 5'd2, 4'd0, 16'h8000, 48'd1250, 2'd2, -16'sd1, 16'sd1));
    send_item(mk_hit(RATE_500, 3'd0, 5'd5, 4'd15, 16'hFFFF, 48'd1100, 2'd3,
                     -16'sd32768, 16'sd32767));
    send_item(mk_hit(10'd0, 3'd3, 5'd3, 4'd7, 16'h0000, 48'hFFFF_FFFF_FFFF, 2'd0,
                     16'sd100, -16'sd100));
    send_item(mk_hit(10'd1023, 3'd7, 5'd4, 4'd9, 16'h1234, 48'h5555_AAAA_5555, 2'd1,
                     16'sh7F00, -16'sh0100));
    send_item(mk_hit(RATE_100, 3'd0, 5'd0, 4'd1, 16'hFFFF, 48'd950, 2'd3, 16'sd1, 16'sd1));
    send_item(mk_hit(RATE_100, 3'd0, 5'd31, 4'd1, 16'hFFFF, 48'd1050, 2'd3, 16'sd2, 16'sd2));
    send_item(mk_hit(RATE_100, 3'd0, 5'd6, 4'd1, 16'hFFFF, 48'd1000, 2'd3, 16'sd3, 16'sd3));
    send_item(mk_hit(RATE_100, 3'd0, 5'd3, 4'd3, 16'h00FF, 48'd900, 2'd2, 16'sd4, -16'sd4));
    send_item(mk_hit(RATE_100, 3'd0, 5'd3, 4'd4, 16'h0F0F, 48'd1101, 2'd1, 16'sd7, 16'sd8));
    send_item(mk_hit(RATE_250, 3'd6, 5'd2, 4'd15, 16'hF0F0, 48'd1376, 2'd0, -16'sd9, 16'sd9));
    send_item(flush_item());
    send_item(flush_item());
    send_item(mk_hit(10'd7, 3'd5, 5'd2, 4'd8, 16'hAAAA, 48'hAAAA_5555_AAAA, 2'd2,
                     16'sd11, 16'sd12));
    send_item(mk_hit(RATE_100, 3'd1, 5'd4, 4'd2, 16'h5555, 48'd1101, 2'd1, 16'sd13, 16'sd14));
    send_item(mk_hit(RATE_500, 3'd2, 5'd5, 4'd6, 16'h0001, 48'hFFFF_FFFF_FFFF, 2'd3,
                     -16'sd15, -16'sd16));
    send_item(mk_hit(RATE_100, 3'd4, 5'd2, 4'd0, 16'h0000, 48'd0, 2'd0, 16'sd0, 16'sd0));
    send_item(mk_hit(RATE_250, 3'd5, 5'd3, 4'd12, 16'h0000, 48'd0, 2'd2, 16'sd17, 16'sd18));
    send_item(flush_item());
    settle();

    set_window(32'd5000);
    for (int c = 1; c < 8; c++) set_first_board(c, 6'($urandom_range(0, 5)));
    hold_req = 1'b1;
    random_events(32);
    settle();

    set_window(32'd0);
    set_first_board(1, 6'd63);
    set_first_board(2, 6'd0);
    for (int c = 3; c < 8; c++) set_first_board(c, 6'($urandom_range(0, 63)));
    random_events(32);
    settle();

    set_window(32'hFFFF_FFFF);
    for (int c = 1; c < 8; c++) set_first_board(c, 6'($urandom_range(0, 3)));
    random_events(32);
    settle();

    if (mismatch_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
